// File: rtl/brf_pkg.sv
// shared constants, types and codes for the byte ring fifo
package brf_pkg;

  // default number of slots in the ring store
  localparam int unsigned MAX_SLOTS_DEF   = 256;
  // width of the ring length register
  localparam int unsigned CFG_W           = 9;
  // data byte width
  localparam int unsigned BYTE_W          = 8;
  // width of the reported free and used counts
  localparam int unsigned CNT_W           = 8;
  // ring length after reset
  localparam int unsigned RING_LENGTH_RST = 256;

  // operation codes carried on kind
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;
    logic load_len;
  } cmd_t;

endpackage

// File: rtl/byte_ring_fifo_unit.sv
// byte ring fifo top level: controller, datapath and checks
// latency: a result strobe appears in the cycle after the command is taken
// no new transaction is taken while the controller is in its response state,
//   in which the byte store's registered read data is presented
// reset: asynchronous, clears both indices and the fill count, ring length 256
// results cannot be held off by the receiver; no clearing pass is needed
module byte_ring_fifo_unit #(
  parameter int unsigned MAX_SLOTS = brf_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [brf_pkg::BYTE_W-1:0]  push_byte_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brf_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic [brf_pkg::BYTE_W-1:0]  popped_byte_o,
  output logic [1:0]                  status_o,
  output logic [brf_pkg::CNT_W-1:0]   free_slots_o,
  output logic [brf_pkg::CNT_W-1:0]   used_slots_o
);
  import brf_pkg::*;

  cmd_t cmd;

  // controller
  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // datapath
  brf_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .push_byte_i   (push_byte_i),
    .cfg_data_i    (cfg_data_i),
    .popped_byte_o (popped_byte_o),
    .status_o      (status_o),
    .free_slots_o  (free_slots_o),
    .used_slots_o  (used_slots_o)
  );

  // every accepted transaction gives a strobe in the next cycle
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("no result after accepted transaction");

  // a strobe lasts one cycle only
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // refused pop reports an empty ring
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |-> (used_slots_o == '0))
    else $error("empty status with bytes held");

  // refused push reports no free slot
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (free_slots_o == '0))
    else $error("full status with free slots");

endmodule

// File: rtl/brf_ram.sv
// generic single-write, single-read ram with registered read data
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/brf_ctrl.sv
// controller state machine: accepts commands and sequences the result strobe
module brf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          cfg_valid_i,
  output logic          busy_o,
  output logic          done_o,
  output logic          cfg_ready_o,
  output brf_pkg::cmd_t cmd_o
);
  import brf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   cfg_ready;

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_RESP;
            busy_q  <= 1'b1;
            done_q  <= 1'b1;
          end
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  // length write only when idle and no transaction starts in the same cycle
  assign cfg_ready = (state_q == S_IDLE) && !start_i;

  // commands to the datapath
  always_comb begin
    cmd_o.exec     = start_i && (state_q == S_IDLE);
    cmd_o.load_len = cfg_valid_i && cfg_ready;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign cfg_ready_o = cfg_ready;

endmodule

// File: rtl/brf_datapath.sv
// datapath: ring indices, fill count, length register and byte store
module brf_datapath #(
  parameter int unsigned MAX_SLOTS = brf_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brf_pkg::cmd_t               cmd_i,
  input  logic                        kind_i,
  input  logic [brf_pkg::BYTE_W-1:0]  push_byte_i,
  input  logic [brf_pkg::CFG_W-1:0]   cfg_data_i,
  output logic [brf_pkg::BYTE_W-1:0]  popped_byte_o,
  output logic [1:0]                  status_o,
  output logic [brf_pkg::CNT_W-1:0]   free_slots_o,
  output logic [brf_pkg::CNT_W-1:0]   used_slots_o
);
  import brf_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned LW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
  localparam logic [LW-1:0] LEN_MIN = LW'(2);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_SLOTS);
  localparam logic [LW-1:0] LEN_RST =
    (RING_LENGTH_RST > MAX_SLOTS) ? LW'(MAX_SLOTS) : LW'(RING_LENGTH_RST);

  logic [LW-1:0]     len_q;
  logic [IW-1:0]     wr_q;
  logic [IW-1:0]     rd_q;
  logic [LW-1:0]     used_q;
  status_e           status_q;
  status_e           status_d;
  logic [LW-1:0]     cfg_ext;
  logic [LW-1:0]     len_cfg;
  logic [LW-1:0]     wr_inc;
  logic [LW-1:0]     rd_inc;
  logic [IW-1:0]     wr_nxt;
  logic [IW-1:0]     rd_nxt;
  logic              full;
  logic              empty;
  logic              do_push;
  logic              do_pop;
  logic              rd_en;
  logic [LW-1:0]     free;
  logic [BYTE_W-1:0] rdata;

  // clamp the written length into the supported range
  always_comb begin
    cfg_ext = LW'(cfg_data_i);
    if (cfg_ext < LEN_MIN) begin
      len_cfg = LEN_MIN;
    end else if (cfg_ext > LEN_MAX) begin
      len_cfg = LEN_MAX;
    end else begin
      len_cfg = cfg_ext;
    end
  end

  // next indices with wrap at the ring length
  always_comb begin
    wr_inc = LW'(wr_q) + LW'(1);
    rd_inc = LW'(rd_q) + LW'(1);
    wr_nxt = (wr_inc == len_q) ? '0 : wr_inc[IW-1:0];
    rd_nxt = (rd_inc == len_q) ? '0 : rd_inc[IW-1:0];
  end

  // full and empty decisions, one slot always left empty
  assign full    = (wr_nxt == rd_q);
  assign empty   = (wr_q == rd_q);
  assign do_push = cmd_i.exec && (kind_i == KIND_PUSH) && !full;
  assign do_pop  = cmd_i.exec && (kind_i == KIND_POP) && !empty;
  assign rd_en   = cmd_i.exec && (kind_i == KIND_POP);

  // result status of the current transaction
  always_comb begin
    if (kind_i == KIND_PUSH) begin
      status_d = full ? ST_FULL : ST_PUSHED;
    end else begin
      status_d = empty ? ST_EMPTY : ST_POPPED;
    end
  end

  // length, indices, fill count and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_RST;
      wr_q     <= '0;
      rd_q     <= '0;
      used_q   <= '0;
      status_q <= ST_PUSHED;
    end else if (cmd_i.load_len) begin
      len_q  <= len_cfg;
      wr_q   <= '0;
      rd_q   <= '0;
      used_q <= '0;
    end else if (cmd_i.exec) begin
      status_q <= status_d;
      if (do_push) begin
        wr_q   <= wr_nxt;
        used_q <= used_q + LW'(1);
      end
      if (do_pop) begin
        rd_q   <= rd_nxt;
        used_q <= used_q - LW'(1);
      end
    end
  end

  // byte store
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_q),
    .wdata_i (push_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // result fields
  assign free          = len_q - LW'(1) - used_q;
  assign free_slots_o  = free[CNT_W-1:0];
  assign used_slots_o  = used_q[CNT_W-1:0];
  assign status_o      = status_q;
  assign popped_byte_o = (status_q == ST_POPPED) ? rdata : '0;

endmodule

// File: tb/sv/byte_ring_fifo_unit_tb.sv
// testbench for the byte ring fifo: directed and random push/pop traffic with a scoreboard
`timescale 1ns / 1ps

// one expected result of a push or pop
typedef struct {
  logic [brf_pkg::BYTE_W-1:0] popped;
  brf_pkg::status_e           status;
  logic [brf_pkg::CNT_W-1:0]  free_n;
  logic [brf_pkg::CNT_W-1:0]  used_n;
} fifo_result_t;

// mirror of the ring state and the queue of results still due
class ring_tracker;
  logic [brf_pkg::BYTE_W-1:0] store [brf_pkg::MAX_SLOTS_DEF];
  int unsigned                wr_idx;
  int unsigned                rd_idx;
  logic [brf_pkg::CFG_W-1:0]  ring_len;
  fifo_result_t               due_results [$];
  int unsigned                errors;

  function new();
    ring_len = brf_pkg::CFG_W'(brf_pkg::RING_LENGTH_RST);
    wr_idx   = 0;
    rd_idx   = 0;
    errors   = 0;
  endfunction

  // ring length in effect, clamped to the legal range
  function int unsigned ring_span();
    int unsigned span;
    span = ring_len;
    if (span < 2) span = 2;
    if (span > brf_pkg::MAX_SLOTS_DEF) span = brf_pkg::MAX_SLOTS_DEF;
    return span;
  endfunction

  // a length write empties the ring, stored bytes stay
  function void load_length(logic [brf_pkg::CFG_W-1:0] len);
    ring_len = len;
    wr_idx   = 0;
    rd_idx   = 0;
  endfunction

  // apply one accepted transaction and queue its result
  function void take_op(logic kind, logic [brf_pkg::BYTE_W-1:0] data);
    fifo_result_t res;
    int unsigned  span;
    int unsigned  nxt;
    int unsigned  held;
    span       = ring_span();
    res.popped = '0;
    if (kind == brf_pkg::KIND_PUSH) begin
      nxt = (wr_idx + 1 == span) ? 0 : wr_idx + 1;
      if (nxt != rd_idx) begin
        store[wr_idx] = data;
        wr_idx        = nxt;
        res.status    = brf_pkg::ST_PUSHED;
      end else begin
        res.status = brf_pkg::ST_FULL;
      end
    end else begin
      if (wr_idx != rd_idx) begin
        res.popped = store[rd_idx];
        rd_idx     = (rd_idx + 1 == span) ? 0 : rd_idx + 1;
        res.status = brf_pkg::ST_POPPED;
      end else begin
        res.status = brf_pkg::ST_EMPTY;
      end
    end
    held       = (wr_idx >= rd_idx) ? wr_idx - rd_idx : span - (rd_idx - wr_idx);
    res.used_n = brf_pkg::CNT_W'(held);
    res.free_n = brf_pkg::CNT_W'(span - 1 - held);
    due_results.push_back(res);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // compare one result strobe with the oldest expectation
  task check_result(logic [brf_pkg::BYTE_W-1:0] popped, logic [1:0] status,
                    logic [brf_pkg::CNT_W-1:0] free_n, logic [brf_pkg::CNT_W-1:0] used_n);
    fifo_result_t exp_res;
    if (due_results.size() == 0) begin
      report("result strobe with no transaction outstanding");
      return;
    end
    exp_res = due_results.pop_front();
    if (status !== exp_res.status)
      report($sformatf("status %0d, wanted %0d", status, exp_res.status));
    if (popped !== exp_res.popped)
      report($sformatf("popped byte %02h, wanted %02h", popped, exp_res.popped));
    if (free_n !== exp_res.free_n)
      report($sformatf("free count %0d, wanted %0d", free_n, exp_res.free_n));
    if (used_n !== exp_res.used_n)
      report($sformatf("used count %0d, wanted %0d", used_n, exp_res.used_n));
  endtask
endclass

module byte_ring_fifo_unit_tb;
  import brf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic              busy_o;
  logic              kind_i      = KIND_PUSH;
  logic [BYTE_W-1:0] push_byte_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i  = '0;
  logic              done_o;
  logic [BYTE_W-1:0] popped_byte_o;
  logic [1:0]        status_o;
  logic [CNT_W-1:0]  free_slots_o;
  logic [CNT_W-1:0]  used_slots_o;

  ring_tracker       sb = new();
  logic              idle_on = 1'b1;
  int unsigned       cycles  = 0;

  byte_ring_fifo_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .push_byte_i  (push_byte_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .popped_byte_o(popped_byte_o),
    .status_o     (status_o),
    .free_slots_o (free_slots_o),
    .used_slots_o (used_slots_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(popped_byte_o, status_o, free_slots_o, used_slots_o);
  end

  // issue one push or pop, with an optional random gap in front
  task automatic send_op(input logic kind, input logic [BYTE_W-1:0] data);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    kind_i      <= kind;
    push_byte_i <= data;
    do @(posedge clk_i); while (busy_o);
    sb.take_op(kind, data);
    @(negedge clk_i);
  endtask

  // write the ring length once all results are in
  task automatic cfg_write(input logic [CFG_W-1:0] len);
    start_i <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.load_length(len);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_lens [10];
    int unsigned      span;
    int               budget;
    int               burst;
    int unsigned      push_pct;
    logic             first;

    phase_lens = '{9'd256, 9'd2, 9'd0, 9'd1, 9'd511, 9'd3, 9'd17, 9'd257, 9'd4, 9'd0};
    phase_lens[8] = CFG_W'($urandom_range(4, 40));
    phase_lens[9] = CFG_W'($urandom_range(0, 511));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset length: pop when empty, extreme bytes through the ring
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'h00);
    send_op(KIND_PUSH, 8'hFF);
    send_op(KIND_POP, 8'hFF);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_POP, 8'h00);

    // shortest ring: one byte fills it, index wraps
    cfg_write(9'd2);
    send_op(KIND_PUSH, 8'h5A);
    send_op(KIND_PUSH, 8'hA5);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'h3C);
    send_op(KIND_POP, 8'hC3);

    // length below range acts as two
    cfg_write(9'd0);
    send_op(KIND_PUSH, 8'h81);
    send_op(KIND_PUSH, 8'h7E);
    send_op(KIND_POP, 8'h00);
    cfg_write(9'd1);
    send_op(KIND_PUSH, 8'h01);
    send_op(KIND_PUSH, 8'h02);

    // length above range acts as the full store; write drops held bytes
    cfg_write(9'd511);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'hC0);
    send_op(KIND_POP, 8'h00);

    // three slots: fill, refuse, wrap the write index
    cfg_write(9'd3);
    send_op(KIND_PUSH, 8'h11);
    send_op(KIND_PUSH, 8'h22);
    send_op(KIND_PUSH, 8'h33);
    send_op(KIND_POP, 8'h00);
    send_op(KIND_PUSH, 8'h44);

    // random phases: a full fill burst first, then bursts of mixed bias
    foreach (phase_lens[p]) begin
      cfg_write(phase_lens[p]);
      span   = sb.ring_span();
      budget = (span > 32) ? 300 : 100;
      first  = 1'b1;
      while (budget > 0) begin
        if (first) begin
          burst    = span + 2;
          push_pct = 100;
          idle_on  = 1'b1;
        end else begin
          burst = $urandom_range(1, span + 4);
          case ($urandom_range(0, 2))
            0:       push_pct = 5;
            1:       push_pct = 50;
            default: push_pct = 95;
          endcase
          idle_on = $urandom_range(0, 1);
        end
        if (burst > budget) burst = budget;
        repeat (burst)
          send_op(($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_POP,
                  BYTE_W'($urandom));
        budget -= burst;
        first   = 1'b0;
      end
    end

    // drain and finish
    start_i <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
